FILE: rtl/sv39ptw_pkg.sv
// sv39ptw_pkg: shared types, field widths and codes of the sv39 page table walker
`timescale 1ns / 1ps
package sv39ptw_pkg;

  localparam int TABLE_PAGES_DEF = 16;

  localparam int PPN_W       = 44;
  localparam int PA_W        = 56;
  localparam int VA_W        = 64;
  localparam int PTE_W       = 64;
  localparam int IDX_W       = 9;
  localparam int TPAGE_W     = 4;
  localparam int STATUS_W    = 3;
  localparam int LEVEL_W     = 2;
  localparam int PAGE_SHIFT  = 12;
  localparam int VA_LIMIT_B  = 38;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 64;

  // command codes
  localparam logic CMD_WRITE     = 1'b0;
  localparam logic CMD_TRANSLATE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UPPER = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LEAF  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_USER  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_POOL  = 3'd5;

  // walk levels
  localparam logic [LEVEL_W-1:0] LVL_ROOT = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_MID  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_LEAF = 2'd0;

  // register indexes (register i at byte address 8*i)
  localparam logic REG_ROOT_PPN  = 1'b0;
  localparam logic REG_POOL_BASE = 1'b1;

  // pte bits
  localparam int PTE_V   = 0;
  localparam int PTE_U   = 4;
  localparam int PTE_PPN_LO = 10;
  localparam int PTE_PPN_HI = 53;

  typedef struct packed {
    logic               command;
    logic [TPAGE_W-1:0] table_page;
    logic [IDX_W-1:0]   entry_index;
    logic [PTE_W-1:0]   entry_value;
    logic [VA_W-1:0]    virtual_address;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PA_W-1:0]     physical_page_address;
    logic [LEVEL_W-1:0]  fault_level;
  } rsp_t;

  typedef struct packed {
    logic [PPN_W-1:0] root_ppn;
    logic [PPN_W-1:0] pool_base_ppn;
  } cfg_t;

endpackage

FILE: rtl/sv39ptw_cfg.sv
// sv39ptw_cfg: apb register block holding root and pool base page numbers
`timescale 1ns / 1ps
module sv39ptw_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sv39ptw_pkg::PADDR_W-1:0] paddr,
  input  logic [sv39ptw_pkg::PDATA_W-1:0] pwdata,
  output logic [sv39ptw_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output sv39ptw_pkg::cfg_t           cfg
);
  import sv39ptw_pkg::*;

  logic reg_sel;
  logic wr_fire;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3];
  assign wr_fire = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_fire) begin
      unique case (reg_sel)
        REG_ROOT_PPN:  cfg.root_ppn      <= pwdata[PPN_W-1:0];
        REG_POOL_BASE: cfg.pool_base_ppn <= pwdata[PPN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ROOT_PPN:  prdata = PDATA_W'(cfg.root_ppn);
      REG_POOL_BASE: prdata = PDATA_W'(cfg.pool_base_ppn);
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: rtl/sv39ptw_store.sv
// sv39ptw_store: single-port pte memory with registered read and a clearing pass after reset
`timescale 1ns / 1ps
module sv39ptw_store #(
  parameter int TABLE_PAGES = sv39ptw_pkg::TABLE_PAGES_DEF,
  parameter int AW = ((TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1) + sv39ptw_pkg::IDX_W
) (
  input  logic                          clk,
  input  logic                          rst,
  output logic                          mem_ready,
  input  logic                          rd_en,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 addr,
  input  logic [sv39ptw_pkg::PTE_W-1:0] wdata,
  output logic [sv39ptw_pkg::PTE_W-1:0] rdata
);
  import sv39ptw_pkg::*;

  localparam int DEPTH = TABLE_PAGES * (1 << IDX_W);

  logic [PTE_W-1:0] mem [DEPTH];
  logic [AW-1:0]    clr_addr;
  logic             clearing;

  assign mem_ready = !clearing;

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: rtl/sv39ptw_walk.sv
// sv39ptw_walk: request sequencer, three-level walk and result register
`timescale 1ns / 1ps
module sv39ptw_walk #(
  parameter int TABLE_PAGES = sv39ptw_pkg::TABLE_PAGES_DEF,
  parameter int AW = ((TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1) + sv39ptw_pkg::IDX_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sv39ptw_pkg::cfg_t             cfg,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  sv39ptw_pkg::req_t             req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output sv39ptw_pkg::rsp_t             rsp,
  input  logic                          mem_ready,
  output logic                          mem_rd,
  output logic                          mem_wr,
  output logic [AW-1:0]                 mem_addr,
  output logic [sv39ptw_pkg::PTE_W-1:0] mem_wdata,
  input  logic [sv39ptw_pkg::PTE_W-1:0] mem_rdata
);
  import sv39ptw_pkg::*;

  localparam int PAGE_W = AW - IDX_W;
  localparam int VAR_W  = VA_LIMIT_B - PAGE_SHIFT;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FINISH} state_t;

  state_t              state;
  logic [LEVEL_W-1:0]  lvl;
  logic [VAR_W-1:0]    va_r;
  logic [STATUS_W-1:0] res_status;
  logic [LEVEL_W-1:0]  res_level;

  logic                accept;
  logic                slot_free;
  logic                page_ok;
  logic [PPN_W-1:0]    chk_ppn;
  logic [PPN_W-1:0]    chk_off;
  logic                chk_in;
  logic [IDX_W-1:0]    rd_idx;
  logic [PPN_W-1:0]    pte_ppn;
  logic                fin;
  logic [STATUS_W-1:0] fin_status;
  logic [LEVEL_W-1:0]  fin_level;
  logic [PA_W-1:0]     fin_pa;

  assign req_ready = (state == S_IDLE) && mem_ready;
  assign accept    = req_valid && req_ready;
  assign slot_free = !rsp_valid || rsp_ready;
  assign page_ok   = 32'(req.table_page) < 32'(TABLE_PAGES);
  assign pte_ppn   = mem_rdata[PTE_PPN_HI:PTE_PPN_LO];

  // shared pool range check: root at accept, followed pointer during the walk
  assign chk_ppn = (state == S_IDLE) ? cfg.root_ppn : pte_ppn;
  assign chk_off = chk_ppn - cfg.pool_base_ppn;
  assign chk_in  = (chk_ppn >= cfg.pool_base_ppn) && (chk_off < PPN_W'(TABLE_PAGES));

  always_comb begin
    if (state == S_IDLE) begin
      rd_idx = req.virtual_address[PAGE_SHIFT + 2*IDX_W +: IDX_W];
    end else if (lvl == LVL_ROOT) begin
      rd_idx = va_r[2*IDX_W-1 -: IDX_W];
    end else begin
      rd_idx = va_r[IDX_W-1:0];
    end
  end

  always_comb begin
    mem_rd     = 1'b0;
    mem_wr     = 1'b0;
    mem_addr   = {chk_off[PAGE_W-1:0], rd_idx};
    mem_wdata  = req.entry_value;
    fin        = 1'b0;
    fin_status = res_status;
    fin_level  = res_level;
    fin_pa     = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && req.command == CMD_WRITE) begin
          mem_wr   = page_ok;
          mem_addr = AW'({req.table_page, req.entry_index});
        end else if (accept && !(|req.virtual_address[VA_W-1:VA_LIMIT_B]) && chk_in) begin
          mem_rd = 1'b1;
        end
      end
      S_WALK: begin
        fin = 1'b1;
        if (lvl != LVL_LEAF) begin
          if (!mem_rdata[PTE_V]) begin
            fin_status = ST_UPPER;
            fin_level  = lvl;
          end else if (!chk_in) begin
            fin_status = ST_POOL;
            fin_level  = lvl - 1'b1;
          end else begin
            fin    = 1'b0;
            mem_rd = 1'b1;
          end
        end else begin
          fin_level = LVL_LEAF;
          if (!mem_rdata[PTE_V]) begin
            fin_status = ST_LEAF;
          end else if (!mem_rdata[PTE_U]) begin
            fin_status = ST_USER;
          end else begin
            fin_status = ST_OK;
            fin_pa     = {pte_ppn, {PAGE_SHIFT{1'b0}}};
          end
        end
      end
      S_FINISH: begin
        fin = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lvl       <= LVL_ROOT;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            va_r <= req.virtual_address[VA_LIMIT_B-1:PAGE_SHIFT];
            lvl  <= LVL_ROOT;
            if (req.command == CMD_WRITE) begin
              res_status <= page_ok ? ST_OK : ST_POOL;
              res_level  <= LVL_LEAF;
              state      <= S_FINISH;
            end else if (|req.virtual_address[VA_W-1:VA_LIMIT_B]) begin
              res_status <= ST_RANGE;
              res_level  <= LVL_ROOT;
              state      <= S_FINISH;
            end else if (!chk_in) begin
              res_status <= ST_POOL;
              res_level  <= LVL_ROOT;
              state      <= S_FINISH;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (mem_rd) begin
            lvl <= lvl - 1'b1;
          end else if (fin && slot_free) begin
            state <= S_IDLE;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (fin && slot_free) begin
        rsp_valid                 <= 1'b1;
        rsp.status                <= fin_status;
        rsp.physical_page_address <= fin_pa;
        rsp.fault_level           <= fin_level;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_no_rd_wr_same_cycle: assert property (@(posedge clk) disable iff (rst)
    !(mem_rd && mem_wr))
    else $error("memory read and write issued together");

  a_read_leads_to_walk: assert property (@(posedge clk) disable iff (rst)
    mem_rd |=> state == S_WALK)
    else $error("memory read issued without entering the walk");

  a_fault_has_no_address: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_OK) |-> rsp.physical_page_address == '0)
    else $error("faulting result carries a page address");

  a_level_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.fault_level != 2'd3)
    else $error("result level beyond the root");

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    !mem_ready |-> !accept)
    else $error("request taken during clearing pass");

endmodule

FILE: rtl/sv39_page_table_walker.sv
// sv39_page_table_walker: top level of the sv39 page table walker with local table pool
//
//  channel   direction  handshake                     payload
//  req       in         req_valid / req_ready         req_t  (write entry or translate)
//  rsp       out        rsp_valid / rsp_ready         rsp_t  (status, page address, level)
//  apb       in         psel, penable, pwrite, pready root_ppn @0x0, pool_base_ppn @0x8
//
// an entry write writes the memory at the accept edge and moves to the finish state,
// where the result is registered once the output register is free
// a translation makes up to three dependent reads of the single-port pte memory,
// one per walk level, each read feeding the next address
// after reset a clearing pass zeroes all TABLE_PAGES*512 pte entries (8192 by
// default); no request is accepted until it ends, register writes are taken throughout
// a stalled result waits in the output register; the walk holds its last read data
// until the register frees, and the next request is taken once the walker is idle
`timescale 1ns / 1ps
module sv39_page_table_walker #(
  parameter int TABLE_PAGES = sv39ptw_pkg::TABLE_PAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            req_valid,
  output logic                            req_ready,
  input  sv39ptw_pkg::req_t               req,
  // result channel
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output sv39ptw_pkg::rsp_t               rsp,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sv39ptw_pkg::PADDR_W-1:0] paddr,
  input  logic [sv39ptw_pkg::PDATA_W-1:0] pwdata,
  output logic [sv39ptw_pkg::PDATA_W-1:0] prdata,
  output logic                            pready
);
  import sv39ptw_pkg::*;

  // pool page bits plus entry index bits
  localparam int AW = ((TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1) + IDX_W;

  cfg_t             cfg;
  logic             mem_ready;
  logic             mem_rd;
  logic             mem_wr;
  logic [AW-1:0]    mem_addr;
  logic [PTE_W-1:0] mem_wdata;
  logic [PTE_W-1:0] mem_rdata;

  // root and pool base registers
  sv39ptw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // pte pool memory, cleared after reset
  sv39ptw_store #(
    .TABLE_PAGES (TABLE_PAGES),
    .AW          (AW)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .mem_ready (mem_ready),
    .rd_en     (mem_rd),
    .wr_en     (mem_wr),
    .addr      (mem_addr),
    .wdata     (mem_wdata),
    .rdata     (mem_rdata)
  );

  // request sequencer and level-by-level walk
  sv39ptw_walk #(
    .TABLE_PAGES (TABLE_PAGES),
    .AW          (AW)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .mem_ready (mem_ready),
    .mem_rd    (mem_rd),
    .mem_wr    (mem_wr),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

endmodule

FILE: verif/sv39_page_table_walker_tb.sv
// sv39_page_table_walker_tb: self-checking testbench of the sv39 page table walker
`timescale 1ns / 1ps
module sv39_page_table_walker_tb;
  import sv39ptw_pkg::*;

  localparam int POOL_PAGES = TABLE_PAGES_DEF;
  localparam int PAGE_ENTRIES = 512;
  // covers the clearing pass after reset, with no request taken, plus the long hold-off
  localparam int STALL_LIMIT = 50000;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_bus = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_bus;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  sv39_page_table_walker u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req_bus),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp_bus),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // shadow of the table pool and of both registers
  logic [PTE_W-1:0] pte_shadow [0:POOL_PAGES*PAGE_ENTRIES-1];
  logic [PPN_W-1:0] root_shadow = '0;
  logic [PPN_W-1:0] base_shadow = '0;

  req_t request_backlog [$];
  rsp_t awaited_rsp [$];
  rsp_t want_rsp;
  int unsigned reqs_offered = 0;
  int unsigned reqs_accepted = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  // idling knobs, percent of cycles
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  // entry indexes that the random part keeps hitting, so walks get past the root
  logic [IDX_W-1:0] hot_idx [0:3];
  logic [PPN_W-1:0] dir_base;

  initial begin
    for (int i = 0; i < POOL_PAGES * PAGE_ENTRIES; i++) pte_shadow[i] = '0;
  end

  // pool page of a table ppn; false when the ppn lies outside the pool
  function automatic bit pool_slot(input logic [PPN_W-1:0] ppn, output int page);
    logic [PPN_W-1:0] off;
    page = 0;
    if (ppn < base_shadow) return 1'b0;
    off = ppn - base_shadow;
    if (off >= POOL_PAGES) return 1'b0;
    page = int'(off);
    return 1'b1;
  endfunction

  // result of one request; an entry write also lands in the shadow pool
  function automatic rsp_t walk_outcome(input req_t r);
    rsp_t res;
    logic [PPN_W-1:0] ppn;
    logic [PTE_W-1:0] pte;
    logic [IDX_W-1:0] idx;
    int page;
    res = '0;
    if (r.command == CMD_WRITE) begin
      if (int'(r.table_page) >= POOL_PAGES) res.status = ST_POOL;
      else pte_shadow[int'(r.table_page) * PAGE_ENTRIES + int'(r.entry_index)] = r.entry_value;
      return res;
    end
    if (r.virtual_address >= (64'd1 << VA_LIMIT_B)) begin
      res.status = ST_RANGE;
      res.fault_level = LVL_ROOT;
      return res;
    end
    ppn = root_shadow;
    for (int lvl = 2; lvl >= 0; lvl--) begin
      if (!pool_slot(ppn, page)) begin
        res.status = ST_POOL;
        res.fault_level = LEVEL_W'(lvl);
        return res;
      end
      idx = r.virtual_address[PAGE_SHIFT + IDX_W * lvl +: IDX_W];
      pte = pte_shadow[page * PAGE_ENTRIES + int'(idx)];
      if (lvl > 0) begin
        // any valid upper entry is a pointer, leaf bits ignored
        if (!pte[PTE_V]) begin
          res.status = ST_UPPER;
          res.fault_level = LEVEL_W'(lvl);
          return res;
        end
        ppn = pte[PTE_PPN_HI:PTE_PPN_LO];
      end else if (!pte[PTE_V]) begin
        res.status = ST_LEAF;
        res.fault_level = LVL_LEAF;
      end else if (!pte[PTE_U]) begin
        res.status = ST_USER;
        res.fault_level = LVL_LEAF;
      end else begin
        res.physical_page_address = {pte[PTE_PPN_HI:PTE_PPN_LO], 12'h000};
      end
    end
    return res;
  endfunction

  function automatic logic [PTE_W-1:0] pointer_pte(input logic [PPN_W-1:0] ppn,
                                                  input logic [9:0] flags);
    return {10'h000, ppn, flags};
  endfunction

  // directed request helpers, unused fields random
  function automatic req_t write_req(input int page, input int idx, input logic [PTE_W-1:0] v);
    req_t r;
    r.command = CMD_WRITE;
    r.table_page = TPAGE_W'(page);
    r.entry_index = IDX_W'(idx);
    r.entry_value = v;
    r.virtual_address = {$urandom, $urandom};
    return r;
  endfunction

  function automatic req_t xlate_req(input logic [VA_W-1:0] va);
    req_t r;
    r.command = CMD_TRANSLATE;
    r.table_page = TPAGE_W'($urandom);
    r.entry_index = IDX_W'($urandom);
    r.entry_value = {$urandom, $urandom};
    r.virtual_address = va;
    return r;
  endfunction

  // random request: mostly table building and walks over the hot entries, some noise
  function automatic req_t random_request();
    req_t r;
    int pick;
    logic [PPN_W-1:0] tgt;
    logic [IDX_W-1:0] top_idx;
    r.table_page = TPAGE_W'($urandom);
    r.entry_index = IDX_W'($urandom);
    r.entry_value = {$urandom, $urandom};
    r.virtual_address = {$urandom, $urandom};
    if ($urandom_range(1, 100) <= 40) begin
      r.command = CMD_WRITE;
      // half of the writes go to the root page, when the root is in the pool
      if ($urandom_range(0, 1) == 1) r.table_page = root_shadow[3:0] - base_shadow[3:0];
      if ($urandom_range(1, 100) <= 85) r.entry_index = hot_idx[$urandom_range(0, 3)];
      pick = $urandom_range(1, 100);
      if (pick <= 60) begin
        tgt = base_shadow + PPN_W'($urandom_range(0, POOL_PAGES - 1));
        if ($urandom_range(1, 100) <= 12) begin
          if ($urandom_range(0, 1) == 1) tgt = base_shadow + PPN_W'(POOL_PAGES + $urandom_range(0, 3));
          else tgt = base_shadow - PPN_W'(1 + $urandom_range(0, 3));
        end
        r.entry_value[PTE_PPN_HI:PTE_PPN_LO] = tgt;
        r.entry_value[PTE_V] = 1'b1;
      end else if (pick <= 90) begin
        // leaf-like entry, mostly valid and user
        r.entry_value[PTE_V] = ($urandom_range(1, 100) <= 90);
        r.entry_value[PTE_U] = ($urandom_range(1, 100) <= 80);
      end
    end else begin
      r.command = CMD_TRANSLATE;
      pick = $urandom_range(1, 100);
      if (pick <= 80) begin
        // root index must stay below 256 to keep the address under the limit
        top_idx = hot_idx[$urandom_range(0, 2)];
        r.virtual_address = {25'b0, 1'b0, top_idx[7:0], hot_idx[$urandom_range(0, 3)],
                             hot_idx[$urandom_range(0, 3)], r.virtual_address[11:0]};
      end else if (pick <= 92) begin
        r.virtual_address = {26'b0, r.virtual_address[37:0]};
      end
    end
    return r;
  endfunction

  // register write: setup cycle, then access cycle until pready
  task automatic reg_write(input logic idx, input logic [PDATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_ROOT_PPN) root_shadow = val[PPN_W-1:0];
    else base_shadow = val[PPN_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (request_backlog.size() != 0 || awaited_rsp.size() != 0 ||
           reqs_accepted != reqs_offered) @(posedge clk);
  endtask

  // one random phase: idle mix, register settings, then a batch of requests
  task automatic run_phase(input int n, input int send_pct, input int recv_pct, input int hold,
                           input logic [PPN_W-1:0] base, input logic [PPN_W-1:0] root);
    wait_drained();
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    reg_write(REG_POOL_BASE, {20'($urandom), base});
    reg_write(REG_ROOT_PPN, {20'($urandom), root});
    hot_idx[0] = ($urandom_range(0, 1) == 1) ? IDX_W'(0) : IDX_W'(255);
    hot_idx[1] = IDX_W'($urandom_range(0, 255));
    hot_idx[2] = IDX_W'($urandom_range(0, 255));
    hot_idx[3] = ($urandom_range(0, 1) == 1) ? IDX_W'(511) : IDX_W'($urandom_range(256, 511));
    hold_left = hold;
    for (int i = 0; i < n; i++) request_backlog.push_back(random_request());
    wait_drained();
  endtask

  // request driver: valid holds with a steady payload until the request is taken
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && reqs_accepted != reqs_offered) begin
      req_valid <= 1'b1;
    end else if (request_backlog.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
      req_bus <= request_backlog.pop_front();
      req_valid <= 1'b1;
      reqs_offered++;
    end else begin
      req_valid <= 1'b0;
    end
  end

  // result receiver: random stalls, or a long hold-off so the walker backs up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_ready <= 1'b0;
      hold_left--;
    end else begin
      rsp_ready <= ($urandom_range(1, 100) > recv_stall_pct);
    end
  end

  // monitor: check results against the oldest prediction, predict each taken request
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          $display("%0t: result with none awaited: %p", $time, rsp_bus);
          fail_count++;
        end else begin
          want_rsp = awaited_rsp.pop_front();
          if (rsp_bus.status !== want_rsp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want_rsp.status,
                     rsp_bus.status);
            fail_count++;
          end
          if (rsp_bus.physical_page_address !== want_rsp.physical_page_address) begin
            $display("%0t: page address expected %h actual %h", $time,
                     want_rsp.physical_page_address, rsp_bus.physical_page_address);
            fail_count++;
          end
          if (rsp_bus.fault_level !== want_rsp.fault_level) begin
            $display("%0t: level expected %0d actual %0d", $time, want_rsp.fault_level,
                     rsp_bus.fault_level);
            fail_count++;
          end
        end
      end
      if (req_valid && req_ready) begin
        awaited_rsp.push_back(walk_outcome(req_bus));
        reqs_accepted++;
      end
    end
  end

  // watchdog on cycles with no request or result taken
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed: root is pool page 2, pool base has junk in the upper pwdata bits
    dir_base = 44'h0AB_CDEF_0123;
    reg_write(REG_POOL_BASE, {20'hFFFFF, dir_base});
    reg_write(REG_ROOT_PPN, {20'h00000, dir_base + 44'd2});
    request_backlog.push_back(xlate_req(64'd0));                      // empty root entry
    request_backlog.push_back(xlate_req(64'd1 << VA_LIMIT_B));        // first address too large
    request_backlog.push_back(xlate_req('1));
    request_backlog.push_back(xlate_req((64'd1 << VA_LIMIT_B) - 1));  // last legal address
    request_backlog.push_back(write_req(2, 0, pointer_pte(dir_base + 44'd5, 10'h001)));
    request_backlog.push_back(xlate_req(64'd0));                      // empty middle entry
    // pointer with read/write/execute set is still followed
    request_backlog.push_back(write_req(5, 0, pointer_pte(dir_base + 44'd15, 10'h00F)));
    request_backlog.push_back(xlate_req(64'd0));                      // leaf invalid
    request_backlog.push_back(write_req(15, 0, pointer_pte('1, 10'h001)));
    request_backlog.push_back(xlate_req(64'd0));                      // leaf not user
    request_backlog.push_back(write_req(15, 0, '1));
    request_backlog.push_back(xlate_req(64'hFFF));                    // largest page address
    // pointers just past the top and just below the base of the pool
    request_backlog.push_back(write_req(2, 255, pointer_pte(dir_base + 44'd16, 10'h001)));
    request_backlog.push_back(xlate_req((64'd1 << VA_LIMIT_B) - 1));
    request_backlog.push_back(write_req(2, 1, pointer_pte(dir_base - 44'd1, 10'h001)));
    request_backlog.push_back(xlate_req(64'd1 << 30));
    request_backlog.push_back(write_req(5, 511, pointer_pte(dir_base, 10'h3FF)));
    request_backlog.push_back(xlate_req({25'b0, 9'd0, 9'd511, 9'd511, 12'hABC}));
    request_backlog.push_back(write_req(0, 511, {10'h3FF, 44'h0, 10'h011}));
    request_backlog.push_back(xlate_req({25'b0, 9'd0, 9'd511, 9'd511, 12'hABC}));
    request_backlog.push_back(write_req(5, 1, pointer_pte(dir_base + 44'd15, 10'h001)));
    request_backlog.push_back(xlate_req({25'b0, 9'd0, 9'd1, 9'd0, 12'h001}));
    wait_drained();
    // root table above and below the pool
    reg_write(REG_ROOT_PPN, {20'h00000, dir_base + 44'd16});
    request_backlog.push_back(xlate_req(64'd0));
    wait_drained();
    reg_write(REG_ROOT_PPN, {20'h00000, dir_base - 44'd1});
    request_backlog.push_back(xlate_req(64'd0));
    wait_drained();

    // random phases over idle mixes and register extremes
    run_phase(200, 0, 0, 0, 44'($urandom_range(0, 1 << 30)), '0);
    run_phase(200, 62, 0, 0, '0, '0);
    run_phase(200, 0, 62, 0, '1 - 44'd15, '1);
    run_phase(200, 25, 25, 0, {12'($urandom), 32'($urandom)}, '0);
    run_phase(200, 0, 0, 400, 44'h800_0000_0000, 44'h800_0000_0007);
    run_phase(150, 25, 25, 0, '1, '1);
    run_phase(80, 62, 0, 0, 44'h000_0010_0000, 44'h000_0010_0013);
    run_phase(170, 0, 0, 0, {12'($urandom), 32'($urandom)}, {12'($urandom), 32'($urandom)});

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaited_rsp.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
